// ===== src/pid_wall_follow_steering_core_macros.svh =====
// Assertion macros shared by the steering core RTL.
// Users must have clk and arst_n in scope; no other dependencies.
`ifndef PID_WALL_FOLLOW_STEERING_CORE_MACROS_SVH
`define PID_WALL_FOLLOW_STEERING_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWFS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PWFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pwfs_pkg.sv =====
// Shared types and constants for the wall-follow steering core.
// No dependencies; imported by every module of the core.
`default_nettype none

package pwfs_pkg;

	localparam int SUM_BITS  = 24;
	localparam int ERR_BITS  = 17;
	localparam int DIFF_BITS = 18;
	localparam int GAIN_BITS = 12;
	localparam int DIST_BITS = 16;
	localparam int DUTY_BITS = 7;
	localparam int PID_BITS  = 16;
	localparam int ACC_BITS  = SUM_BITS + GAIN_BITS + 3;
	localparam int FRAC_BITS = 8;

	localparam int IN_TDATA_BITS  = 48;
	localparam int OUT_TDATA_BITS = 40;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [DUTY_BITS-1:0] TURN_LEFT_DUTY   = 7'd20;
	localparam logic [DUTY_BITS-1:0] TURN_RIGHT_DUTY  = 7'd90;
	localparam logic [7:0]           STOP_BEACON      = 8'd3;
	localparam logic [7:0]           MAX_KNOWN_BEACON = 8'd3;

	localparam logic [DIST_BITS-1:0] RST_TARGET_DISTANCE = 16'd40;
	localparam logic [GAIN_BITS-1:0] RST_GAIN_P          = 12'd205;
	localparam logic [GAIN_BITS-1:0] RST_GAIN_I          = 12'd0;
	localparam logic [GAIN_BITS-1:0] RST_GAIN_D          = 12'd1024;
	localparam logic [DIST_BITS-1:0] RST_FRONT_LIMIT     = 16'd27;
	localparam logic [DUTY_BITS-1:0] RST_SPEED_HIGH      = 7'd80;
	localparam logic [DUTY_BITS-1:0] RST_SPEED_LOW       = 7'd50;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TARGET_DISTANCE = 3'd0,
		REG_GAIN_P          = 3'd1,
		REG_GAIN_I          = 3'd2,
		REG_GAIN_D          = 3'd3,
		REG_FRONT_LIMIT     = 3'd4,
		REG_SPEED_HIGH      = 3'd5,
		REG_SPEED_LOW       = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] target_distance;
		logic [GAIN_BITS-1:0] gain_p;
		logic [GAIN_BITS-1:0] gain_i_times_period;
		logic [GAIN_BITS-1:0] gain_d_over_period;
		logic [DIST_BITS-1:0] front_limit;
		logic [DUTY_BITS-1:0] speed_high;
		logic [DUTY_BITS-1:0] speed_low;
	} cfg_t;

	typedef struct packed {
		logic [7:0]           beacon_id;
		logic                 beacon_valid;
		logic                 control_tick;
		logic [DIST_BITS-1:0] side_distance;
		logic [DIST_BITS-1:0] front_distance;
	} in_item_t;

	typedef struct packed {
		logic                 beacon_known;
		logic                 turning;
		logic                 halted;
		logic [PID_BITS-1:0]  pid_value;
		logic [DUTY_BITS-1:0] right_duty;
		logic [DUTY_BITS-1:0] left_duty;
	} out_item_t;

	typedef struct packed {
		logic active;
		logic commit;
	} step_ctl_t;

endpackage

`default_nettype wire

// ===== src/pwfs_cfg.sv =====
// Configuration register file of the steering core.
// Depends on pwfs_pkg for the register map and reset values.
`default_nettype none

module pwfs_cfg
	import pwfs_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                          cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_distance     <= RST_TARGET_DISTANCE;
			cfg_q.gain_p              <= RST_GAIN_P;
			cfg_q.gain_i_times_period <= RST_GAIN_I;
			cfg_q.gain_d_over_period  <= RST_GAIN_D;
			cfg_q.front_limit         <= RST_FRONT_LIMIT;
			cfg_q.speed_high          <= RST_SPEED_HIGH;
			cfg_q.speed_low           <= RST_SPEED_LOW;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET_DISTANCE: cfg_q.target_distance <= cfg_data;
				REG_GAIN_P: cfg_q.gain_p <= cfg_data[GAIN_BITS-1:0];
				REG_GAIN_I: cfg_q.gain_i_times_period <= cfg_data[GAIN_BITS-1:0];
				REG_GAIN_D: cfg_q.gain_d_over_period <= cfg_data[GAIN_BITS-1:0];
				REG_FRONT_LIMIT: cfg_q.front_limit <= cfg_data;
				REG_SPEED_HIGH: cfg_q.speed_high <= cfg_data[DUTY_BITS-1:0];
				REG_SPEED_LOW: cfg_q.speed_low <= cfg_data[DUTY_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/pwfs_pid.sv =====
// Fixed-point PID datapath with its integrator and history registers.
// Depends on pwfs_pkg for widths, the configuration and control structs.
`default_nettype none

module pwfs_pid
	import pwfs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire step_ctl_t            ctl,
	input  wire cfg_t                 cfg,
	input  wire logic [DIST_BITS-1:0] side_distance,
	output logic [PID_BITS-1:0]       pid_value
);

	localparam int Q_BITS = ACC_BITS - FRAC_BITS;

	logic signed [SUM_BITS-1:0]  error_sum_q;
	logic signed [ERR_BITS-1:0]  last_error_q;
	logic [PID_BITS-1:0]         last_pid_q;

	logic signed [ERR_BITS-1:0]  err;
	logic signed [SUM_BITS:0]    sum_wide;
	logic signed [SUM_BITS-1:0]  sum_next;
	logic signed [DIFF_BITS-1:0] diff;
	logic signed [ACC_BITS-1:0]  prod_p;
	logic signed [ACC_BITS-1:0]  prod_i;
	logic signed [ACC_BITS-1:0]  prod_d;
	logic signed [ACC_BITS-1:0]  acc;
	logic signed [ACC_BITS-1:0]  acc_adj;
	logic [Q_BITS-1:0]           quot;
	logic [PID_BITS-1:0]         pid_new;

	always_comb begin
		err = $signed({1'b0, cfg.target_distance}) - $signed({1'b0, side_distance});

		sum_wide = $signed({error_sum_q[SUM_BITS-1], error_sum_q})
			+ $signed({{(SUM_BITS + 1 - ERR_BITS){err[ERR_BITS-1]}}, err});
		if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
			sum_next = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
				: {1'b0, {(SUM_BITS-1){1'b1}}};
		end else begin
			sum_next = sum_wide[SUM_BITS-1:0];
		end

		diff = $signed({err[ERR_BITS-1], err}) - $signed({last_error_q[ERR_BITS-1], last_error_q});

		prod_p = $signed({{(ACC_BITS-GAIN_BITS){1'b0}}, cfg.gain_p})
			* $signed({{(ACC_BITS-ERR_BITS){err[ERR_BITS-1]}}, err});
		prod_i = $signed({{(ACC_BITS-GAIN_BITS){1'b0}}, cfg.gain_i_times_period})
			* $signed({{(ACC_BITS-SUM_BITS){sum_next[SUM_BITS-1]}}, sum_next});
		prod_d = $signed({{(ACC_BITS-GAIN_BITS){1'b0}}, cfg.gain_d_over_period})
			* $signed({{(ACC_BITS-DIFF_BITS){diff[DIFF_BITS-1]}}, diff});
		acc = prod_p + prod_i + prod_d;

		// Division by 256 rounds toward zero, so negative sums are biased first.
		acc_adj = acc[ACC_BITS-1] ? acc + ACC_BITS'((1 << FRAC_BITS) - 1) : acc;
		quot    = acc_adj[ACC_BITS-1:FRAC_BITS];

		if ((&quot[Q_BITS-1:PID_BITS-1]) || !(|quot[Q_BITS-1:PID_BITS-1])) begin
			pid_new = quot[PID_BITS-1:0];
		end else begin
			pid_new = quot[Q_BITS-1] ? {1'b1, {(PID_BITS-1){1'b0}}}
				: {1'b0, {(PID_BITS-1){1'b1}}};
		end

		pid_value = ctl.active ? pid_new : last_pid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
			last_pid_q   <= '0;
		end else if (ctl.commit) begin
			error_sum_q  <= sum_next;
			last_error_q <= err;
			last_pid_q   <= pid_new;
		end
	end

endmodule

`default_nettype wire

// ===== src/pwfs_steer.sv =====
// Wheel speed state, obstacle turn, beacon stop latch and result assembly.
// Depends on pwfs_pkg for the configuration, item and control types.
`default_nettype none

module pwfs_steer
	import pwfs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire step_ctl_t           ctl,
	input  wire cfg_t                cfg,
	input  wire in_item_t            item,
	input  wire logic [PID_BITS-1:0] pid_value,
	output logic                     stop_latched,
	output out_item_t                result
);

	localparam int V_BITS = PID_BITS + 2;

	logic [DUTY_BITS-1:0] left_q;
	logic [DUTY_BITS-1:0] right_q;
	logic                 stop_q;

	logic                 turn;
	logic                 known;
	logic                 stop_hit;
	logic                 speed_upd;
	logic [DUTY_BITS-1:0] left_next;
	logic [DUTY_BITS-1:0] right_next;
	logic signed [V_BITS-1:0] pid_ext;
	logic signed [V_BITS-1:0] right_sum;
	logic signed [V_BITS-1:0] left_sum;

	function automatic logic [DUTY_BITS-1:0] clamp_speed(
		input logic signed [V_BITS-1:0] v,
		input logic [DUTY_BITS-1:0]     hi,
		input logic [DUTY_BITS-1:0]     lo
	);
		logic signed [V_BITS-1:0] hi_ext;
		logic signed [V_BITS-1:0] lo_ext;
		logic signed [V_BITS-1:0] r;
		hi_ext = $signed({{(V_BITS-DUTY_BITS){1'b0}}, hi});
		lo_ext = $signed({{(V_BITS-DUTY_BITS){1'b0}}, lo});
		r = v;
		if (r > hi_ext) r = hi_ext;
		if (r < lo_ext) r = lo_ext;
		return r[DUTY_BITS-1:0];
	endfunction

	always_comb begin
		turn     = item.front_distance < cfg.front_limit;
		known    = item.beacon_valid && (item.beacon_id <= MAX_KNOWN_BEACON);
		stop_hit = item.beacon_valid && (item.beacon_id == STOP_BEACON);

		pid_ext   = $signed({{(V_BITS-PID_BITS){pid_value[PID_BITS-1]}}, pid_value});
		right_sum = $signed({{(V_BITS-DUTY_BITS){1'b0}}, right_q}) + pid_ext;
		left_sum  = $signed({{(V_BITS-DUTY_BITS){1'b0}}, left_q}) - pid_ext;

		speed_upd = item.control_tick && !turn;
		if (!speed_upd) begin
			left_next  = left_q;
			right_next = right_q;
		end else if (pid_value == '0) begin
			left_next  = cfg.speed_high;
			right_next = cfg.speed_high;
		end else begin
			left_next  = clamp_speed(left_sum, cfg.speed_high, cfg.speed_low);
			right_next = clamp_speed(right_sum, cfg.speed_high, cfg.speed_low);
		end

		result.pid_value = pid_value;
		if (!ctl.active) begin
			result.left_duty    = '0;
			result.right_duty   = '0;
			result.halted       = 1'b1;
			result.turning      = 1'b0;
			result.beacon_known = 1'b0;
		end else begin
			result.left_duty    = turn ? TURN_LEFT_DUTY : left_next;
			result.right_duty   = turn ? TURN_RIGHT_DUTY : right_next;
			result.halted       = 1'b0;
			result.turning      = turn;
			result.beacon_known = known;
		end
	end

	assign stop_latched = stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= RST_SPEED_HIGH;
			right_q <= RST_SPEED_HIGH;
			stop_q  <= 1'b0;
		end else if (ctl.commit) begin
			left_q  <= left_next;
			right_q <= right_next;
			if (stop_hit) begin
				stop_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/pid_wall_follow_steering_core.sv =====
// Top level of the wall-follow steering core: input and result registers,
// handshakes, and the cfg, PID and steering blocks. Depends on pwfs_pkg.
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  sensor and beacon request
// m_*       out        m_tvalid / m_tready  wheel duties and status
// cfg_*     in         cfg_valid/cfg_ready  register index and value
//
// A result passes through the input register and then the result register; a new
// request can be accepted every cycle while the output is not stalled.
// The PID multiplies, integrator and speed clamps all sit in the combinational logic
// between the input register and the result register.
// A stalled result holds while one more request waits in the input register.
// Reset is asynchronous, active low; it restores all register reset values.
`default_nettype none
`include "pid_wall_follow_steering_core_macros.svh"

module pid_wall_follow_steering_core
	import pwfs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// front_distance[15:0], side_distance[31:16], control_tick[32],
	// beacon_valid[33], beacon_id[41:34], zero fill above.
	input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// left_duty[6:0], right_duty[13:7], pid_value[29:14], halted[30],
	// turning[31], beacon_known[32], zero fill above.
	output logic [OUT_TDATA_BITS-1:0]      m_tdata,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int ITEM_BITS = $bits(in_item_t);
	localparam int RES_BITS  = $bits(out_item_t);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;
	logic      advance;
	logic      stop_latched;
	step_ctl_t pid_ctl;
	step_ctl_t steer_ctl;
	logic [PID_BITS-1:0] pid_value;
	out_item_t result;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_TDATA_BITS-RES_BITS){1'b0}}, res_s2};

	always_comb begin
		steer_ctl.active = valid_s1 && !stop_latched;
		steer_ctl.commit = steer_ctl.active && advance;
		pid_ctl.active   = steer_ctl.active && item_s1.control_tick;
		pid_ctl.commit   = pid_ctl.active && advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= in_item_t'(s_tdata[ITEM_BITS-1:0]);
		end
		if (advance && valid_s1) begin
			res_s2 <= result;
		end
	end

	pwfs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pwfs_pid u_pid (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (pid_ctl),
		.cfg           (cfg),
		.side_distance (item_s1.side_distance),
		.pid_value     (pid_value)
	);

	pwfs_steer u_steer (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (steer_ctl),
		.cfg          (cfg),
		.item         (item_s1),
		.pid_value    (pid_value),
		.stop_latched (stop_latched),
		.result       (result)
	);

	`PWFS_ASSERT(a_halted_duties, valid_s2 && res_s2.halted, (res_s2.left_duty == '0) && (res_s2.right_duty == '0) && !res_s2.turning, "halted result drives nonzero duty")
	`PWFS_ASSERT(a_turn_duties, valid_s2 && res_s2.turning, (res_s2.left_duty == TURN_LEFT_DUTY) && (res_s2.right_duty == TURN_RIGHT_DUTY), "turn result has wrong duties")
	`PWFS_ASSERT(a_full_stall, valid_s1 && valid_s2 && !m_tready, !s_tready, "request accepted while both registers are full")
	`PWFS_ASSERT_NEXT(a_latch_sticky, stop_latched, stop_latched, "stop latch cleared without reset")

endmodule

`default_nettype wire

// ===== verif/pid_wall_follow_steering_core_tb.sv =====
// Self-checking testbench for the wall-follow steering core: directed table, then
// register phases with random sensor requests, checked against a local predictor.
// Depends on pwfs_pkg and pid_wall_follow_steering_core.
`timescale 1ns / 1ps

module pid_wall_follow_steering_core_tb;
	import pwfs_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIR_N = 17;

	typedef struct packed {
		logic [15:0] front;
		logic [15:0] side;
		logic        tick;
		logic        bval;
		logic [7:0]  bid;
		logic        typed;
		logic [6:0]  left;
		logic [6:0]  right;
		logic [15:0] pid;
		logic        halt;
		logic        turn;
		logic        known;
	} dir_row_t;

	// The first seven rows hold values worked out by hand for the reset settings.
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{16'd100,   16'd40,    1'b0, 1'b0, 8'd0,   1'b1, 7'd80, 7'd80, 16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd0,     16'd0,     1'b0, 1'b0, 8'd0,   1'b1, 7'd20, 7'd90, 16'd0,     1'b0, 1'b1, 1'b0},
		'{16'd65535, 16'd65535, 1'b0, 1'b1, 8'd0,   1'b1, 7'd80, 7'd80, 16'd0,     1'b0, 1'b0, 1'b1},
		'{16'd26,    16'd40,    1'b0, 1'b1, 8'd255, 1'b1, 7'd20, 7'd90, 16'd0,     1'b0, 1'b1, 1'b0},
		'{16'd27,    16'd40,    1'b1, 1'b0, 8'd0,   1'b1, 7'd80, 7'd80, 16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd1000,  16'd0,     1'b1, 1'b0, 8'd0,   1'b1, 7'd50, 7'd80, 16'd192,   1'b0, 1'b0, 1'b0},
		'{16'd1000,  16'd65535, 1'b1, 1'b0, 8'd0,   1'b1, 7'd80, 7'd50, 16'h8000,  1'b0, 1'b0, 1'b0},
		'{16'd500,   16'd40,    1'b1, 1'b1, 8'd1,   1'b0, 7'd0,  7'd0,  16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd10,    16'd30,    1'b1, 1'b1, 8'd2,   1'b0, 7'd0,  7'd0,  16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd300,   16'd45,    1'b1, 1'b1, 8'd4,   1'b0, 7'd0,  7'd0,  16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd300,   16'd40,    1'b0, 1'b0, 8'd3,   1'b0, 7'd0,  7'd0,  16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd300,   16'd40,    1'b1, 1'b0, 8'hAA,  1'b0, 7'd0,  7'd0,  16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd300,   16'd39,    1'b1, 1'b1, 8'h55,  1'b0, 7'd0,  7'd0,  16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd65535, 16'd0,     1'b1, 1'b0, 8'd0,   1'b0, 7'd0,  7'd0,  16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd0,     16'd65535, 1'b1, 1'b0, 8'd0,   1'b0, 7'd0,  7'd0,  16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd27,    16'd40,    1'b1, 1'b0, 8'd0,   1'b0, 7'd0,  7'd0,  16'd0,     1'b0, 1'b0, 1'b0},
		'{16'd27,    16'd40,    1'b1, 1'b0, 8'd0,   1'b0, 7'd0,  7'd0,  16'd0,     1'b0, 1'b0, 1'b0}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [IN_TDATA_BITS-1:0]  s_tdata;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	pid_wall_follow_steering_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state and register copy.
	cfg_t   regs;
	longint integ_acc;
	longint prev_err;
	int     held_pid;
	int     lspd;
	int     rspd;
	bit     stopped;

	out_item_t awaited_steer [$];
	int        mismatches = 0;
	int        n_sent = 0;
	int        n_checked = 0;
	int        n_turning = 0;
	int        n_halted = 0;
	int        burst_left = 0;
	logic [8:0] stall_cnt = '0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("Timeout waiting for results");
		$display("Mismatches found");
		$finish;
	end

	function automatic int clamp_duty(int v);
		if (v > int'(regs.speed_high))
			v = int'(regs.speed_high);
		if (v < int'(regs.speed_low))
			v = int'(regs.speed_low);
		return v;
	endfunction

	function automatic out_item_t steer_predict(in_item_t it);
		out_item_t r;
		longint    e;
		longint    acc;
		longint    q;
		longint    smax;
		longint    smin;
		smax = (longint'(1) << (SUM_BITS - 1)) - 1;
		smin = -smax - 1;
		r = '0;
		if (stopped) begin
			r.halted = 1'b1;
			r.pid_value = PID_BITS'(held_pid);
			return r;
		end
		if (it.beacon_valid) begin
			r.beacon_known = (it.beacon_id <= MAX_KNOWN_BEACON);
			if (it.beacon_id == STOP_BEACON)
				stopped = 1'b1;
		end
		if (it.control_tick) begin
			e = longint'(regs.target_distance) - longint'(it.side_distance);
			integ_acc = integ_acc + e;
			if (integ_acc > smax)
				integ_acc = smax;
			if (integ_acc < smin)
				integ_acc = smin;
			acc = longint'(regs.gain_p) * e
				+ longint'(regs.gain_i_times_period) * integ_acc
				+ longint'(regs.gain_d_over_period) * (e - prev_err);
			prev_err = e;
			q = acc / 256;
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			held_pid = int'(q);
		end
		if (it.front_distance < regs.front_limit) begin
			r.turning = 1'b1;
			r.left_duty = TURN_LEFT_DUTY;
			r.right_duty = TURN_RIGHT_DUTY;
		end else begin
			if (it.control_tick) begin
				if (held_pid == 0) begin
					rspd = int'(regs.speed_high);
					lspd = int'(regs.speed_high);
				end else begin
					rspd = clamp_duty(rspd + held_pid);
					lspd = clamp_duty(lspd - held_pid);
				end
			end
			r.left_duty = DUTY_BITS'(lspd);
			r.right_duty = DUTY_BITS'(rspd);
		end
		r.pid_value = PID_BITS'(held_pid);
		return r;
	endfunction

	function automatic in_item_t make_request(int tick_pct, bit far_side, bit allow_stop);
		in_item_t it;
		int       r;
		int       d;
		r = $urandom_range(0, 99);
		if (r < 15 && regs.front_limit != 0)
			it.front_distance = 16'($urandom_range(0, int'(regs.front_limit) - 1));
		else if (r < 20)
			it.front_distance = regs.front_limit;
		else if (r < 30)
			it.front_distance = 16'($urandom);
		else
			it.front_distance = 16'($urandom_range(int'(regs.front_limit), 65535));
		if (far_side) begin
			if (regs.target_distance >= 16'd32768)
				it.side_distance = 16'($urandom_range(0, 1023));
			else
				it.side_distance = 16'($urandom_range(64512, 65535));
		end else if ($urandom_range(0, 99) < 30) begin
			it.side_distance = 16'($urandom);
		end else begin
			d = int'(regs.target_distance) + $urandom_range(0, 128) - 64;
			if (d < 0)
				d = 0;
			if (d > 65535)
				d = 65535;
			it.side_distance = 16'(d);
		end
		it.control_tick = ($urandom_range(0, 99) < tick_pct);
		it.beacon_valid = ($urandom_range(0, 3) == 0);
		it.beacon_id = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		if (!allow_stop && it.beacon_valid && it.beacon_id == STOP_BEACON)
			it.beacon_id = it.beacon_id ^ 8'd1;
		return it;
	endfunction

	task automatic push_request(in_item_t it, bit typed, out_item_t typed_val);
		out_item_t pred;
		int        gap;
		s_tdata <= IN_TDATA_BITS'(it);
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		pred = steer_predict(it);
		awaited_steer.push_back(typed ? typed_val : pred);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 23);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		while (awaited_steer.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_TARGET_DISTANCE: regs.target_distance = val;
			REG_GAIN_P:          regs.gain_p = val[GAIN_BITS-1:0];
			REG_GAIN_I:          regs.gain_i_times_period = val[GAIN_BITS-1:0];
			REG_GAIN_D:          regs.gain_d_over_period = val[GAIN_BITS-1:0];
			REG_FRONT_LIMIT:     regs.front_limit = val;
			REG_SPEED_HIGH:      regs.speed_high = val[DUTY_BITS-1:0];
			REG_SPEED_LOW:       regs.speed_low = val[DUTY_BITS-1:0];
			default: ;
		endcase
	endtask

	// Unused upper data bits are filled with noise; the block must ignore them.
	task automatic program_regs(cfg_t c, bit touch_spare);
		write_reg(REG_TARGET_DISTANCE, c.target_distance);
		write_reg(REG_GAIN_P, {4'($urandom), c.gain_p});
		write_reg(REG_GAIN_I, {4'($urandom), c.gain_i_times_period});
		write_reg(REG_GAIN_D, {4'($urandom), c.gain_d_over_period});
		write_reg(REG_FRONT_LIMIT, c.front_limit);
		write_reg(REG_SPEED_HIGH, {9'($urandom), c.speed_high});
		write_reg(REG_SPEED_LOW, {9'($urandom), c.speed_low});
		if (touch_spare)
			write_reg(REG_SPARE, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 9'd1;
		case (stall_cnt[8:7])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= stall_cnt[2] ^ stall_cnt[4];
			default: m_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
			if (awaited_steer.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unrequested result l=%0d r=%0d pid=%0d",
						got.left_duty, got.right_duty, $signed(got.pid_value));
			end else begin
				want = awaited_steer.pop_front();
				n_checked++;
				if (got.turning)
					n_turning++;
				if (got.halted)
					n_halted++;
				if (got.left_duty !== want.left_duty || got.right_duty !== want.right_duty
						|| got.pid_value !== want.pid_value || got.halted !== want.halted
						|| got.turning !== want.turning
						|| got.beacon_known !== want.beacon_known) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"ERROR: result %0d differs: exp l=%0d r=%0d pid=%0d h=%b t=%b",
							" k=%b, got l=%0d r=%0d pid=%0d h=%b t=%b k=%b"},
							n_checked, want.left_duty, want.right_duty,
							$signed(want.pid_value), want.halted, want.turning,
							want.beacon_known, got.left_duty, got.right_duty,
							$signed(got.pid_value), got.halted, got.turning, got.beacon_known);
				end
			end
		end
	end

	initial begin
		cfg_t      c;
		in_item_t  it;
		out_item_t tv;
		dir_row_t  row;
		int        n_items;
		int        tick_pct;
		bit        far_side;
		int        n_phases;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		regs = '{RST_TARGET_DISTANCE, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D,
			RST_FRONT_LIMIT, RST_SPEED_HIGH, RST_SPEED_LOW};
		integ_acc = 0;
		prev_err = 0;
		held_pid = 0;
		lspd = int'(RST_SPEED_HIGH);
		rspd = int'(RST_SPEED_HIGH);
		stopped = 1'b0;
		n_phases = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			row = DIR_ROWS[i];
			it = '0;
			it.front_distance = row.front;
			it.side_distance = row.side;
			it.control_tick = row.tick;
			it.beacon_valid = row.bval;
			it.beacon_id = row.bid;
			tv = '0;
			tv.left_duty = row.left;
			tv.right_duty = row.right;
			tv.pid_value = row.pid;
			tv.halted = row.halt;
			tv.turning = row.turn;
			tv.beacon_known = row.known;
			push_request(it, row.typed, tv);
		end

		for (int p = 0; p <= 10; p++) begin
			s_tvalid <= 1'b0;
			drain_results();
			n_items = 115;
			tick_pct = 70;
			far_side = 1'b0;
			c = regs;
			case (p)
				0: n_items = 100;
				1: begin
					// Full-scale gains with a wall far away drive the integrator into its upper rail.
					c = '{16'd65535, 12'd4095, 12'd4095, 12'd4095, 16'd0, 7'd127, 7'd0};
					n_items = 180;
					tick_pct = 95;
					far_side = 1'b1;
				end
				2: begin
					c = '{16'd0, 12'd0, 12'd0, 12'd0, 16'd65535, 7'd0, 7'd127};
					n_items = 80;
				end
				3: c = '{16'd40, 12'd205, 12'd0, 12'd1024, 16'd27, 7'd30, 7'd100};
				4: begin
					c = '{16'd0, 12'd300, 12'd4095, 12'd100, 16'd50, 7'd100, 7'd0};
					n_items = 180;
					tick_pct = 95;
					far_side = 1'b1;
				end
				default: begin
					c.target_distance = ($urandom_range(0, 3) == 0) ?
						16'($urandom) : 16'($urandom_range(10, 400));
					c.gain_p = $urandom_range(0, 1) ?
						12'($urandom_range(0, 600)) : 12'($urandom);
					c.gain_i_times_period = $urandom_range(0, 1) ?
						12'($urandom_range(0, 64)) : 12'($urandom);
					c.gain_d_over_period = $urandom_range(0, 1) ?
						12'($urandom_range(0, 1200)) : 12'($urandom);
					c.front_limit = 16'($urandom_range(0, 300));
					c.speed_high = 7'($urandom_range(50, 110));
					c.speed_low = 7'($urandom_range(0, 70));
				end
			endcase
			if (p != 0) begin
				program_regs(c, p == 2);
				n_phases++;
			end
			for (int k = 0; k < n_items; k++)
				push_request(make_request(tick_pct, far_side, 1'b0), 1'b0, '0);
		end

		// Last phase: reset-like settings, random requests, then the stop beacon and requests after it.
		s_tvalid <= 1'b0;
		drain_results();
		c = '{RST_TARGET_DISTANCE, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D,
			RST_FRONT_LIMIT, RST_SPEED_HIGH, RST_SPEED_LOW};
		program_regs(c, 1'b0);
		n_phases++;
		for (int k = 0; k < 40; k++)
			push_request(make_request(70, 1'b0, 1'b0), 1'b0, '0);
		it = '0;
		it.front_distance = 16'd300;
		it.side_distance = regs.target_distance + 16'd5;
		it.control_tick = 1'b1;
		it.beacon_valid = 1'b1;
		it.beacon_id = STOP_BEACON;
		push_request(it, 1'b0, '0);
		for (int k = 0; k < 60; k++)
			push_request(make_request(70, 1'b0, 1'b1), 1'b0, '0);
		s_tvalid <= 1'b0;
		drain_results();

		$display("Sent %0d sensor requests under %0d register settings after the reset one.",
			n_sent, n_phases);
		$display("Compared %0d results: %0d in obstacle turns, %0d after the stop beacon.",
			n_checked, n_turning, n_halted);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
